// ===== src/led_matrix_scroll_scanner_macros.svh =====
// ---------------------------------------------------------------------------
// led_matrix_scroll_scanner assertion macros
// shared property wrappers for the scanner checker
// ---------------------------------------------------------------------------
`ifndef LED_MATRIX_SCROLL_SCANNER_MACROS_SVH
`define LED_MATRIX_SCROLL_SCANNER_MACROS_SVH

// same-cycle implication, quiet during reset
`define LMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define LMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset cycles
`define LMS_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lms_pkg.sv =====
// ---------------------------------------------------------------------------
// lms_pkg
// command codes, register indexes and shared types of the scroll scanner
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lms_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_DWELL   = 2'd0;
  localparam logic [1:0] REG_REFRESH = 2'd1;
  localparam logic [1:0] REG_LENGTH  = 2'd2;

  localparam logic [15:0] DWELL_RESET   = 16'd1000;
  localparam logic [7:0]  REFRESH_RESET = 8'd10;
  localparam logic [6:0]  LENGTH_RESET  = 7'd54;

  localparam int IDX_W  = 6;
  localparam int DATA_W = 8;
  localparam int CFG_W  = 16;

  // what the output stage needs besides the row data
  typedef struct packed {
    logic       running;
    logic       in_range;
    logic [7:0] col_en_n;
  } view_t;

endpackage

// ===== src/lms_scan_ctrl.sv =====
// ---------------------------------------------------------------------------
// lms_scan_ctrl
// config registers, dwell/column/refresh/shift counters and read address
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lms_scan_ctrl
  import lms_pkg::*;
#(
  parameter int MESSAGE_DEPTH   = 64,
  parameter int DISPLAY_COLUMNS = 8,
  parameter int AW              = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              accept,
  input  cmd_t              cmd,
  output logic [AW-1:0]     rd_addr,
  output view_t             view
);

  localparam int CW = $clog2(DISPLAY_COLUMNS);
  localparam int SW = $clog2(MESSAGE_DEPTH + 1);
  localparam int LW = $clog2(MESSAGE_DEPTH + DISPLAY_COLUMNS + 128);
  localparam logic [CW-1:0] LAST_COL = CW'(DISPLAY_COLUMNS - 1);

  logic [15:0]   dwell_ticks_r;
  logic [7:0]    refreshes_r;
  logic [6:0]    length_r;

  logic [SW-1:0] shift_r, shift_nxt;
  logic [7:0]    refresh_r, refresh_nxt;
  logic [CW-1:0] lit_r, lit_nxt;
  logic [15:0]   dwell_r, dwell_nxt;
  logic          running_r, running_nxt;

  logic [LW-1:0] used_len;
  logic [LW-1:0] shift_inc;
  logic [16:0]   dwell_inc;
  logic [8:0]    refresh_inc;
  logic [LW-1:0] pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= DWELL_RESET;
      refreshes_r   <= REFRESH_RESET;
      length_r      <= LENGTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DWELL:   dwell_ticks_r <= cfg_wdata;
        REG_REFRESH: refreshes_r   <= cfg_wdata[7:0];
        REG_LENGTH:  length_r      <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    used_len = (LW'(length_r) > LW'(MESSAGE_DEPTH)) ? LW'(MESSAGE_DEPTH) : LW'(length_r);
    dwell_inc   = {1'b0, dwell_r} + 17'd1;
    refresh_inc = {1'b0, refresh_r} + 9'd1;
    shift_inc   = LW'(shift_r) + LW'(1);

    shift_nxt   = shift_r;
    refresh_nxt = refresh_r;
    lit_nxt     = lit_r;
    dwell_nxt   = dwell_r;
    running_nxt = running_r;

    unique case (cmd)
      CMD_START: begin
        shift_nxt   = '0;
        refresh_nxt = '0;
        lit_nxt     = '0;
        dwell_nxt   = '0;
        running_nxt = (used_len >= LW'(DISPLAY_COLUMNS));
      end
      CMD_TICK: begin
        if (running_r) begin
          if (dwell_inc < {1'b0, dwell_ticks_r}) begin
            dwell_nxt = dwell_inc[15:0];
          end else begin
            dwell_nxt = '0;
            if (lit_r != LAST_COL) begin
              lit_nxt = lit_r + CW'(1);
            end else begin
              lit_nxt = '0;
              if (refresh_inc < {1'b0, refreshes_r}) begin
                refresh_nxt = refresh_inc[7:0];
              end else begin
                refresh_nxt = '0;
                // window runs past the message end: blank and stop
                if (shift_inc + LW'(DISPLAY_COLUMNS) > used_len) begin
                  running_nxt = 1'b0;
                  shift_nxt   = '0;
                end else begin
                  shift_nxt = SW'(shift_inc);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= '0;
      refresh_r <= '0;
      lit_r     <= '0;
      dwell_r   <= '0;
      running_r <= 1'b0;
    end else if (accept) begin
      shift_r   <= shift_nxt;
      refresh_r <= refresh_nxt;
      lit_r     <= lit_nxt;
      dwell_r   <= dwell_nxt;
      running_r <= running_nxt;
    end
  end

  // read address and column select come from the post-update state
  always_comb begin
    pos              = LW'(shift_nxt) + LW'(lit_nxt);
    rd_addr          = pos[AW-1:0];
    view.running     = running_nxt;
    view.in_range    = (pos < LW'(MESSAGE_DEPTH));
    view.col_en_n    = 8'hFF;
    for (int i = 0; i < 8; i++) begin
      if (LW'(lit_nxt) == LW'(i)) begin
        view.col_en_n[i] = 1'b0;
      end
    end
  end

endmodule

// ===== src/lms_msg_store.sv =====
// ---------------------------------------------------------------------------
// lms_msg_store
// message column memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lms_msg_store
  import lms_pkg::*;
#(
  parameter int MESSAGE_DEPTH = 64,
  parameter int AW            = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [MESSAGE_DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write and a read of the same entry in one cycle: read sees the new data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

// ===== src/led_matrix_scroll_scanner.sv =====
// ---------------------------------------------------------------------------
// led_matrix_scroll_scanner
// column-scan driver for an LED matrix that scrolls a stored message
// ---------------------------------------------------------------------------
// Every input transfer (column write, start or tick) yields exactly one output
// transfer carrying the row levels, active-low column enables and done flag as
// they stand after that command. The block takes one transfer per cycle when
// the output side is ready; each result passes through the message store
// read (single write port plus one registered read port) and then the
// output register. A write and a read of the same column in one transfer are
// forwarded. Configuration writes belong in idle periods. No clearing pass:
// unwritten store columns read as unknown.
`timescale 1ns / 1ps

module led_matrix_scroll_scanner
  import lms_pkg::*;
#(
  parameter int MESSAGE_DEPTH   = 64,
  parameter int DISPLAY_COLUMNS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // command stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [5:0] column_index, [13:6] column_data
  input  logic [1:0]        in_tuser,   // [1:0] cmd
  // display stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [7:0] row_drive, [15:8] column_enable_n
  output logic              out_tuser   // [0] scroll_done
);

  localparam int AW = $clog2(MESSAGE_DEPTH);
  localparam int IW = $clog2(MESSAGE_DEPTH + 64);

  logic              accept;
  cmd_t              cmd;
  logic [IDX_W-1:0]  col_index;
  logic [DATA_W-1:0] col_data;

  logic              wr_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  view_t             view;

  // read stage: store output is valid here
  logic              a_valid_r;
  view_t             a_view_r;
  logic              a_move;

  // output register
  logic              out_valid_r;
  logic [7:0]        row_r;
  logic [7:0]        en_n_r;
  logic              done_r;

  assign cmd       = cmd_t'(in_tuser);
  assign col_index = in_tdata[5:0];
  assign col_data  = in_tdata[13:6];

  // the read stage hands over whenever the output register is free or draining
  assign a_move    = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_move;
  assign accept    = in_tvalid && in_tready;

  // writes beyond the store are dropped
  assign wr_en = accept && (cmd == CMD_WRITE) && (IW'(col_index) < IW'(MESSAGE_DEPTH));

  lms_scan_ctrl #(
    .MESSAGE_DEPTH   (MESSAGE_DEPTH),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .AW              (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .view      (view)
  );

  lms_msg_store #(
    .MESSAGE_DEPTH (MESSAGE_DEPTH),
    .AW            (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(col_index)),
    .wr_data (col_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read stage bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_view_r <= view;
    end
  end

  // output register: idle shows a blank display with done set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      if (a_view_r.running) begin
        row_r  <= a_view_r.in_range ? rd_data : 8'h00;
        en_n_r <= a_view_r.col_en_n;
        done_r <= 1'b0;
      end else begin
        row_r  <= 8'h00;
        en_n_r <= 8'hFF;
        done_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {en_n_r, row_r};
  assign out_tuser  = done_r;

endmodule

// ===== src/lms_checker.sv =====
// ---------------------------------------------------------------------------
// lms_checker
// port-level checks of the scroll scanner, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_matrix_scroll_scanner_macros.svh"

module lms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // done means a fully blanked display
  `LMS_ASSERT_NOW(a_done_blank, clk, rst_n, out_tvalid && out_tuser, (out_tdata == 16'hFF00), "done transfer with lit display")

  // while scrolling at most one column is enabled
  `LMS_ASSERT_NOW(a_one_column, clk, rst_n, out_tvalid && !out_tuser, $onehot0(~out_tdata[15:8]), "more than one column enabled")

  // a stalled result holds
  `LMS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // nothing leaves right after reset
  `LMS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind led_matrix_scroll_scanner lms_checker u_lms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
